FILE: src/ppbs_pkg.sv
// shared constants and control types for the proportional power budget scaler
package ppbs_pkg;

    localparam int POWER_W = 16;
    localparam int MOD_CNT = 4;
    localparam int IDX_W   = $clog2(MOD_CNT);
    localparam int SUM_W   = POWER_W + IDX_W;
    localparam int PROD_W  = 2 * POWER_W;
    localparam int STEP_W  = $clog2(POWER_W);

    localparam logic [POWER_W-1:0] LIMIT_RESET = POWER_W'(6400);
    localparam logic [POWER_W-1:0] GRANT_RESET = POWER_W'(1280);

    typedef struct packed {
        logic             load;
        logic             sum;
        logic             pass;
        logic             mul;
        logic             div_load;
        logic             div_step;
        logic             store;
        logic [IDX_W-1:0] idx;
    } ppbs_cmd_t;

    typedef struct packed {
        logic any_ready;
        logic over_limit;
    } ppbs_stat_t;

endpackage

FILE: src/ppbs_dp.sv
// datapath: request capture, sum, multiplier, restoring divider, held grants
module ppbs_dp
    import ppbs_pkg::*;
(
    input  logic               aclk,
    input  logic               aresetn,
    input  logic               cfg_valid,
    input  logic               cfg_ready,
    input  logic [POWER_W-1:0] cfg_power_limit,
    input  logic [3:0]         s_ready_mask,
    input  logic [POWER_W-1:0] s_request_a,
    input  logic [POWER_W-1:0] s_request_b,
    input  logic [POWER_W-1:0] s_request_c,
    input  logic [POWER_W-1:0] s_request_d,
    input  ppbs_cmd_t          cmd,
    output ppbs_stat_t         stat,
    output logic [POWER_W-1:0] m_grant_a,
    output logic [POWER_W-1:0] m_grant_b,
    output logic [POWER_W-1:0] m_grant_c,
    output logic [POWER_W-1:0] m_grant_d,
    output logic               m_was_scaled
);

    logic [POWER_W-1:0] limit_reg;
    logic [POWER_W-1:0] req_reg [MOD_CNT];
    logic [POWER_W-1:0] held_reg [MOD_CNT];
    logic               flag_reg;
    logic               any_reg;
    logic [SUM_W-1:0]   sum_reg;
    logic [PROD_W-1:0]  prod_reg;
    logic [SUM_W-1:0]   rem_reg;
    logic [POWER_W-1:0] quo_reg;

    logic [SUM_W+1:0]   trial;
    logic               qbit;

    // one long-division step: shift the next dividend bit into the remainder
    assign trial = {1'b0, rem_reg, quo_reg[POWER_W-1]} - (SUM_W+2)'(sum_reg);
    assign qbit  = ~trial[SUM_W+1];

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            limit_reg <= LIMIT_RESET;
            flag_reg  <= 1'b0;
            for (int i = 0; i < MOD_CNT; i++) begin
                held_reg[i] <= GRANT_RESET;
            end
        end else begin
            if (cfg_valid && cfg_ready) begin
                limit_reg <= cfg_power_limit;
            end
            if (cmd.pass) begin
                for (int i = 0; i < MOD_CNT; i++) begin
                    held_reg[i] <= req_reg[i];
                end
                flag_reg <= 1'b0;
            end
            if (cmd.store) begin
                held_reg[cmd.idx] <= quo_reg;
                flag_reg          <= 1'b1;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (cmd.load) begin
            req_reg[0] <= s_request_a;
            req_reg[1] <= s_request_b;
            req_reg[2] <= s_request_c;
            req_reg[3] <= s_request_d;
            any_reg    <= |s_ready_mask;
        end
        if (cmd.sum) begin
            sum_reg <= SUM_W'(req_reg[0]) + SUM_W'(req_reg[1])
                     + SUM_W'(req_reg[2]) + SUM_W'(req_reg[3]);
        end
        if (cmd.mul) begin
            prod_reg <= PROD_W'(req_reg[cmd.idx]) * PROD_W'(limit_reg);
        end
        // request <= sum, so the quotient fits the low half
        if (cmd.div_load) begin
            rem_reg <= SUM_W'(prod_reg[PROD_W-1:POWER_W]);
            quo_reg <= prod_reg[POWER_W-1:0];
        end else if (cmd.div_step) begin
            if (qbit) begin
                rem_reg <= trial[SUM_W-1:0];
            end else begin
                rem_reg <= {rem_reg[SUM_W-2:0], quo_reg[POWER_W-1]};
            end
            quo_reg <= {quo_reg[POWER_W-2:0], qbit};
        end
    end

    assign stat.any_ready  = any_reg;
    assign stat.over_limit = sum_reg > SUM_W'(limit_reg);

    assign m_grant_a    = held_reg[0];
    assign m_grant_b    = held_reg[1];
    assign m_grant_c    = held_reg[2];
    assign m_grant_d    = held_reg[3];
    assign m_was_scaled = flag_reg;

    // the divider start value must be below the divisor for a 16-bit quotient
    a_div_start: assert property (@(posedge aclk) disable iff (!aresetn)
        cmd.div_load |-> (SUM_W'(prod_reg[PROD_W-1:POWER_W]) < sum_reg))
        else $error("divider start remainder not below sum");

    // a scaled grant never exceeds the budget
    a_grant_bound: assert property (@(posedge aclk) disable iff (!aresetn)
        cmd.store |-> (quo_reg <= limit_reg))
        else $error("scaled grant above power limit");

endmodule

FILE: src/ppbs_ctrl.sv
// controller: sequences sum, compare and per-module multiply/divide
module ppbs_ctrl
    import ppbs_pkg::*;
(
    input  logic       aclk,
    input  logic       aresetn,
    input  logic       s_valid,
    output logic       s_ready,
    output logic       m_valid,
    input  logic       m_ready,
    input  ppbs_stat_t stat,
    output ppbs_cmd_t  cmd
);

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_SUM,
        ST_DECIDE,
        ST_MUL,
        ST_LOAD,
        ST_DIV,
        ST_STORE,
        ST_OUT
    } state_t;

    state_t            state_reg, state_next;
    logic [IDX_W-1:0]  idx_reg, idx_next;
    logic [STEP_W-1:0] step_reg, step_next;

    always_comb begin
        state_next = state_reg;
        idx_next   = idx_reg;
        step_next  = step_reg;
        cmd        = '0;
        cmd.idx    = idx_reg;
        s_ready    = 1'b0;
        m_valid    = 1'b0;
        unique case (state_reg)
            ST_IDLE: begin
                s_ready  = 1'b1;
                cmd.load = s_valid;
                if (s_valid) begin
                    state_next = ST_SUM;
                end
            end
            ST_SUM: begin
                cmd.sum    = 1'b1;
                state_next = ST_DECIDE;
            end
            ST_DECIDE: begin
                if (!stat.any_ready) begin
                    state_next = ST_OUT;
                end else if (stat.over_limit) begin
                    idx_next   = '0;
                    state_next = ST_MUL;
                end else begin
                    cmd.pass   = 1'b1;
                    state_next = ST_OUT;
                end
            end
            ST_MUL: begin
                cmd.mul    = 1'b1;
                state_next = ST_LOAD;
            end
            ST_LOAD: begin
                cmd.div_load = 1'b1;
                step_next    = '0;
                state_next   = ST_DIV;
            end
            ST_DIV: begin
                cmd.div_step = 1'b1;
                step_next    = step_reg + 1'b1;
                if (step_reg == STEP_W'(POWER_W - 1)) begin
                    state_next = ST_STORE;
                end
            end
            ST_STORE: begin
                cmd.store = 1'b1;
                if (idx_reg == IDX_W'(MOD_CNT - 1)) begin
                    state_next = ST_OUT;
                end else begin
                    idx_next   = idx_reg + 1'b1;
                    state_next = ST_MUL;
                end
            end
            ST_OUT: begin
                m_valid = 1'b1;
                if (m_ready) begin
                    state_next = ST_IDLE;
                end
            end
            default: begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= ST_IDLE;
            idx_reg   <= '0;
            step_reg  <= '0;
        end else begin
            state_reg <= state_next;
            idx_reg   <= idx_next;
            step_reg  <= step_next;
        end
    end

    // one item at a time: no new transfer right after an input transfer
    a_busy: assert property (@(posedge aclk) disable iff (!aresetn)
        (s_valid && s_ready) |=> !s_ready)
        else $error("input accepted while busy");

    // a result transfer returns the block to accepting
    a_back_idle: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_valid && m_ready) |=> (s_ready && !m_valid))
        else $error("not idle after result transfer");

    // a result is never offered while input is open
    a_exclusive: assert property (@(posedge aclk) disable iff (!aresetn)
        !(s_ready && m_valid))
        else $error("input ready while result pending");

endmodule

FILE: src/proportional_power_budget_scaler.sv
// top level of the proportional power budget scaler
//
//  channel   direction  ports
//  cfg       in         cfg_valid, cfg_ready, cfg_power_limit
//  s         in         s_valid, s_ready, s_ready_mask, s_request_a..d
//  m         out        m_valid, m_ready, m_grant_a..d, m_was_scaled
//
// no ready bit or no scaling: the item passes ST_SUM and ST_DECIDE, then m_valid rises in ST_OUT
// scaling: after ST_DECIDE each module in turn runs multiply, divider load, 16 divide steps and store,
// then m_valid rises in ST_OUT; the shared bit-serial divider sets the scaling time
// one item is in flight; s_ready is high only while idle
// a stalled m_ready holds the result and blocks the next input
// synchronous reset restores 100 W limit and 20 W grants; cfg_ready is always high
module proportional_power_budget_scaler
    import ppbs_pkg::*;
(
    input  logic               aclk,
    input  logic               aresetn,
    input  logic               cfg_valid,
    output logic               cfg_ready,
    input  logic [POWER_W-1:0] cfg_power_limit,
    input  logic               s_valid,
    output logic               s_ready,
    input  logic [3:0]         s_ready_mask,
    input  logic [POWER_W-1:0] s_request_a,
    input  logic [POWER_W-1:0] s_request_b,
    input  logic [POWER_W-1:0] s_request_c,
    input  logic [POWER_W-1:0] s_request_d,
    output logic               m_valid,
    input  logic               m_ready,
    output logic [POWER_W-1:0] m_grant_a,
    output logic [POWER_W-1:0] m_grant_b,
    output logic [POWER_W-1:0] m_grant_c,
    output logic [POWER_W-1:0] m_grant_d,
    output logic               m_was_scaled
);

    ppbs_cmd_t  cmd;
    ppbs_stat_t stat;

    assign cfg_ready = 1'b1;

    ppbs_ctrl u_ctrl (
        .aclk    (aclk),
        .aresetn (aresetn),
        .s_valid (s_valid),
        .s_ready (s_ready),
        .m_valid (m_valid),
        .m_ready (m_ready),
        .stat    (stat),
        .cmd     (cmd)
    );

    ppbs_dp u_dp (
        .aclk            (aclk),
        .aresetn         (aresetn),
        .cfg_valid       (cfg_valid),
        .cfg_ready       (cfg_ready),
        .cfg_power_limit (cfg_power_limit),
        .s_ready_mask    (s_ready_mask),
        .s_request_a     (s_request_a),
        .s_request_b     (s_request_b),
        .s_request_c     (s_request_c),
        .s_request_d     (s_request_d),
        .cmd             (cmd),
        .stat            (stat),
        .m_grant_a       (m_grant_a),
        .m_grant_b       (m_grant_b),
        .m_grant_c       (m_grant_c),
        .m_grant_d       (m_grant_d),
        .m_was_scaled    (m_was_scaled)
    );

endmodule

FILE: sim/tb.sv
// testbench for the proportional power budget scaler: directed, limit-extreme, random and stall tests
`timescale 1ns / 100ps

module tb;
    import ppbs_pkg::*;

    localparam int CYCLE_LIMIT = 2_000_000;

    typedef enum {
        IDLE_NONE,
        IDLE_SEND,
        IDLE_RECV,
        IDLE_BOTH
    } idle_mode_t;

    typedef struct packed {
        logic [3:0]                       mask;
        logic [MOD_CNT-1:0][POWER_W-1:0] req;
    } request_t;

    typedef struct packed {
        logic [MOD_CNT-1:0][POWER_W-1:0] grant;
        logic                             scaled;
    } grant_set_t;

    logic               aclk;
    logic               aresetn         = 1'b0;
    logic               cfg_valid       = 1'b0;
    logic               cfg_ready;
    logic [POWER_W-1:0] cfg_power_limit = '0;
    logic               s_valid         = 1'b0;
    logic               s_ready;
    logic [3:0]         s_ready_mask    = '0;
    logic [POWER_W-1:0] s_request_a     = '0;
    logic [POWER_W-1:0] s_request_b     = '0;
    logic [POWER_W-1:0] s_request_c     = '0;
    logic [POWER_W-1:0] s_request_d     = '0;
    logic               m_valid;
    logic               m_ready         = 1'b0;
    logic [POWER_W-1:0] m_grant_a;
    logic [POWER_W-1:0] m_grant_b;
    logic [POWER_W-1:0] m_grant_c;
    logic [POWER_W-1:0] m_grant_d;
    logic               m_was_scaled;

    // predictor state
    logic [POWER_W-1:0]               budget_limit = LIMIT_RESET;
    logic [MOD_CNT-1:0][POWER_W-1:0] held_grant   = {MOD_CNT{GRANT_RESET}};
    logic                             held_scaled  = 1'b0;

    grant_set_t expected_grants[$];
    idle_mode_t idle_mode     = IDLE_NONE;
    int         mismatch_count = 0;
    int         cycle_count    = 0;
    int         hold_request   = 0;
    int         hold_left      = 0;

    proportional_power_budget_scaler DUT (
        .aclk            (aclk),
        .aresetn         (aresetn),
        .cfg_valid       (cfg_valid),
        .cfg_ready       (cfg_ready),
        .cfg_power_limit (cfg_power_limit),
        .s_valid         (s_valid),
        .s_ready         (s_ready),
        .s_ready_mask    (s_ready_mask),
        .s_request_a     (s_request_a),
        .s_request_b     (s_request_b),
        .s_request_c     (s_request_c),
        .s_request_d     (s_request_d),
        .m_valid         (m_valid),
        .m_ready         (m_ready),
        .m_grant_a       (m_grant_a),
        .m_grant_b       (m_grant_b),
        .m_grant_c       (m_grant_c),
        .m_grant_d       (m_grant_d),
        .m_was_scaled    (m_was_scaled)
    );

    initial begin
        aclk = 1'b0;
        forever #5 aclk = ~aclk;
    end

    always @(posedge aclk) begin
        cycle_count++;
        if (cycle_count > CYCLE_LIMIT) begin
            $display("CHECKS FAILED");
            $finish;
        end
    end

    // updates the held grants for one accepted request and returns what gets output
    function automatic grant_set_t budget_scale(request_t it);
        logic [SUM_W-1:0] total;
        logic [63:0]      prod;
        grant_set_t       res;
        total = '0;
        if (it.mask != 4'd0) begin
            for (int i = 0; i < MOD_CNT; i++) total += SUM_W'(it.req[i]);
            if (total > SUM_W'(budget_limit)) begin
                for (int i = 0; i < MOD_CNT; i++) begin
                    prod = 64'(it.req[i]) * 64'(budget_limit);
                    held_grant[i] = POWER_W'(prod / 64'(total));
                end
                held_scaled = 1'b1;
            end else begin
                held_grant  = it.req;
                held_scaled = 1'b0;
            end
        end
        res.grant  = held_grant;
        res.scaled = held_scaled;
        return res;
    endfunction

    function automatic int stall_percent(bit sender);
        case (idle_mode)
            IDLE_SEND: return sender ? 67 : 0;
            IDLE_RECV: return sender ? 0 : 67;
            IDLE_BOTH: return 18;
            default:   return 0;
        endcase
    endfunction

    // receiver side: drives m_ready and checks every result transfer
    always @(posedge aclk) begin
        grant_set_t act;
        grant_set_t exp_set;
        string      names[MOD_CNT];
        names = '{"grant_a", "grant_b", "grant_c", "grant_d"};
        if (aresetn && m_valid && m_ready) begin
            act.grant  = {m_grant_d, m_grant_c, m_grant_b, m_grant_a};
            act.scaled = m_was_scaled;
            if (expected_grants.size() == 0) begin
                $error("result transfer with no pending request");
                mismatch_count++;
            end else begin
                exp_set = expected_grants.pop_front();
                for (int i = 0; i < MOD_CNT; i++) begin
                    if (act.grant[i] !== exp_set.grant[i]) begin
                        $error("%s expected %0d actual %0d", names[i],
                               exp_set.grant[i], act.grant[i]);
                        mismatch_count++;
                    end
                end
                if (act.scaled !== exp_set.scaled) begin
                    $error("was_scaled expected %0d actual %0d", exp_set.scaled, act.scaled);
                    mismatch_count++;
                end
            end
        end
        if (hold_request > 0) begin
            hold_left    = hold_request;
            hold_request = 0;
        end
        if (hold_left > 0) begin
            hold_left--;
            m_ready <= 1'b0;
        end else begin
            m_ready <= ($urandom_range(99) >= stall_percent(1'b0));
        end
    end

    // leaves s_valid high when the next request follows without a gap
    task automatic send_request(request_t it);
        int gap;
        gap = 0;
        while ($urandom_range(99) < stall_percent(1'b1)) gap++;
        if (gap > 0) begin
            s_valid <= 1'b0;
            repeat (gap) @(posedge aclk);
        end
        s_valid      <= 1'b1;
        s_ready_mask <= it.mask;
        s_request_a  <= it.req[0];
        s_request_b  <= it.req[1];
        s_request_c  <= it.req[2];
        s_request_d  <= it.req[3];
        do @(posedge aclk); while (!s_ready);
        expected_grants.push_back(budget_scale(it));
    endtask

    task automatic send_fields(logic [3:0] mask, logic [POWER_W-1:0] a, logic [POWER_W-1:0] b,
                               logic [POWER_W-1:0] c, logic [POWER_W-1:0] d);
        request_t it;
        it.mask = mask;
        it.req  = {d, c, b, a};
        send_request(it);
    endtask

    task automatic wait_for_drain();
        s_valid <= 1'b0;
        while (expected_grants.size() != 0) @(posedge aclk);
        repeat (4) @(posedge aclk);
    endtask

    task automatic write_limit(logic [POWER_W-1:0] value);
        wait_for_drain();
        cfg_valid       <= 1'b1;
        cfg_power_limit <= value;
        do @(posedge aclk); while (!cfg_ready);
        cfg_valid    <= 1'b0;
        budget_limit  = value;
    endtask

    function automatic logic [POWER_W-1:0] pick_request();
        int sel;
        sel = $urandom_range(99);
        if (sel < 10) return '0;
        if (sel < 20) return '1;
        if (sel < 55) return POWER_W'($urandom);
        // otherwise at most a third of the limit plus one so the pass-through path gets exercised
        return POWER_W'($urandom_range(int'(budget_limit) / 3 + 1));
    endfunction

    function automatic request_t pick_item();
        request_t it;
        it.mask = ($urandom_range(99) < 15) ? 4'd0 : 4'($urandom);
        for (int i = 0; i < MOD_CNT; i++) it.req[i] = pick_request();
        return it;
    endfunction

    task automatic test_directed();
        idle_mode = IDLE_NONE;
        // held grants straight after reset
        send_fields(4'b0000, 16'd7, 16'd7, 16'd7, 16'd7);
        // zero sum passes through
        send_fields(4'b1111, 16'd0, 16'd0, 16'd0, 16'd0);
        // sum equal to limit is not scaled
        send_fields(4'b1111, 16'd1600, 16'd1600, 16'd1600, 16'd1600);
        send_fields(4'b0001, 16'd1000, 16'd3000, 16'd2000, 16'd1000);
        send_fields(4'b0010, 16'd65535, 16'd65535, 16'd65535, 16'd65535);
        // no ready bit keeps the scaled grants and flag
        send_fields(4'b0000, 16'hffff, 16'h0000, 16'hffff, 16'h0000);
        send_fields(4'b0100, 16'd100, 16'd200, 16'd300, 16'd400);
        send_fields(4'b1000, 16'd65535, 16'd0, 16'd0, 16'd1);
        send_fields(4'b1111, 16'd6401, 16'd0, 16'd0, 16'd0);
        send_fields(4'b0101, 16'h5555, 16'haaaa, 16'h5555, 16'haaaa);
    endtask

    task automatic test_limit_extremes();
        write_limit(16'd0);
        // zero limit with nonzero sum grants nothing
        send_fields(4'b1111, 16'd1, 16'd0, 16'd0, 16'd0);
        send_fields(4'b1010, 16'd65535, 16'd65535, 16'd65535, 16'd65535);
        send_fields(4'b0000, 16'd5, 16'd5, 16'd5, 16'd5);
        send_fields(4'b1111, 16'd0, 16'd0, 16'd0, 16'd0);
        write_limit(16'd65535);
        send_fields(4'b1111, 16'd65535, 16'd65535, 16'd65535, 16'd65535);
        send_fields(4'b1111, 16'd16383, 16'd16384, 16'd16384, 16'd16384);
        send_fields(4'b1111, 16'd16384, 16'd16384, 16'd16384, 16'd16384);
        send_fields(4'b0011, 16'd65535, 16'd0, 16'd0, 16'd0);
        write_limit(LIMIT_RESET);
    endtask

    task automatic test_random(idle_mode_t mode, logic [POWER_W-1:0] limit, int count);
        write_limit(limit);
        idle_mode = mode;
        for (int n = 0; n < count; n++) send_request(pick_item());
        wait_for_drain();
    endtask

    // long receiver hold-off while requests keep coming, so the input stalls
    task automatic test_backpressure();
        write_limit(POWER_W'($urandom));
        idle_mode    = IDLE_NONE;
        hold_request = 400;
        for (int n = 0; n < 24; n++) send_request(pick_item());
        wait_for_drain();
    endtask

    initial begin
        repeat (9) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);
        test_directed();
        test_limit_extremes();
        test_random(IDLE_NONE, LIMIT_RESET, 310);
        test_random(IDLE_SEND, POWER_W'($urandom), 310);
        test_random(IDLE_RECV, 16'hffff, 310);
        test_random(IDLE_BOTH, POWER_W'($urandom_range(500)), 310);
        test_random(IDLE_NONE, POWER_W'($urandom), 310);
        test_backpressure();
        wait_for_drain();
        repeat (100) @(posedge aclk);
        if (mismatch_count == 0) begin
            $display("ALL CHECKS PASSED");
        end else begin
            $display("CHECKS FAILED");
        end
        $finish;
    end

endmodule
